// ===== src/slipcrc_pkg.sv =====
// Shared constants and types for the SLIP frame receiver with CRC-16 check.
package slipcrc_pkg;

   // SLIP framing symbols
   localparam logic [7:0] SymEnd    = 8'hC0;
   localparam logic [7:0] SymEsc    = 8'hDB;
   localparam logic [7:0] SymEscEnd = 8'hDC;
   localparam logic [7:0] SymEscEsc = 8'hDD;

   // CRC-16/Modbus, reflected
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // frame capacity in decoded bytes; counter holds 0..MaxFrame
   localparam int MaxFrame = 64;
   localparam int LenWidth = 7;

   typedef struct packed {
      logic                data_valid;
      logic [7:0]          data_byte;
      logic                frame_done;
      logic [LenWidth-1:0] frame_length;
      logic                crc_ok;
      logic                address_match;
      logic                frame_aborted;
      logic                overflow;
   } rsp_type;

endpackage

// ===== src/slipcrc_crc_byte.sv =====
// One-byte CRC-16/Modbus update, bitwise reflected form.
module slipcrc_crc_byte (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ slipcrc_pkg::CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// ===== src/slip_frame_receiver_crc_check_core.sv =====
// SLIP frame receiver: unescaping, frame tracking, CRC-16/Modbus and address check.
//
//  channel   ports                           direction   handshake
//  --------  ------------------------------  ----------  ------------------
//  request   req_rx_byte                     in          req_valid/req_ready
//  response  rsp_data_valid .. rsp_overflow  out         rsp_valid/rsp_ready
//  csr       csr_wr_data (local_address)     in          csr_wr_en, no wait
//
// One item per cycle sustained while rsp_ready stays high. An accepted byte is
// held in the input register, is decoded against the frame state there, and its
// result lands in the output register, which drives rsp_valid.
// A stalled rsp_ready holds the output register; the input register then fills
// and req_ready drops in the same cycle. Reset (synchronous) empties both
// registers and returns the receiver to idle, waiting for an opening 0xC0.
module slip_frame_receiver_crc_check_core (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_data_valid,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_frame_done,
   output logic [slipcrc_pkg::LenWidth-1:0]    rsp_frame_length,
   output logic                                rsp_crc_ok,
   output logic                                rsp_address_match,
   output logic                                rsp_frame_aborted,
   output logic                                rsp_overflow,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [7:0]                          csr_wr_data
);

   localparam int LW = slipcrc_pkg::LenWidth;

   // configuration
   logic [7:0] local_address_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // output register
   logic                 out_valid_ff, out_valid_in;
   slipcrc_pkg::rsp_type out_ff, out_in;

   // frame state
   logic          in_frame_ff,  in_frame_in;
   logic          esc_ff,       esc_in;
   logic [LW-1:0] count_ff,     count_in;
   logic [15:0]   crc_ff,       crc_in;
   logic [7:0]    tail0_ff,     tail0_in;   // older of the two trailing bytes
   logic [7:0]    tail1_ff,     tail1_in;
   logic [7:0]    first_ff,     first_in;
   logic          ovf_ff,       ovf_in;

   logic        out_free;
   logic        advance;
   logic [15:0] crc_fed;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // CRC trails the data by two bytes so the received CRC never enters it
   slipcrc_crc_byte u_crc (
      .crc_in  (crc_ff),
      .data_in (tail0_ff),
      .crc_out (crc_fed)
   );

   // decode of the byte in the input register
   always_comb begin
      logic [7:0] dec;
      logic       have;
      logic       clear;
      dec   = in_byte_ff;
      have  = 1'b0;
      clear = 1'b0;

      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      tail0_in    = tail0_ff;
      tail1_in    = tail1_ff;
      first_in    = first_ff;
      ovf_in      = ovf_ff;
      out_in      = '0;

      if (!in_frame_ff) begin
         // hunting for an opening delimiter
         if (in_byte_ff == slipcrc_pkg::SymEnd) begin
            in_frame_in = 1'b1;
            clear       = 1'b1;
         end
      end else if (in_byte_ff == slipcrc_pkg::SymEnd) begin
         if (count_ff == '0 && !ovf_ff) begin
            // back-to-back delimiters: stay open
            esc_in = 1'b0;
         end else begin
            out_in.frame_done    = 1'b1;
            out_in.frame_length  = count_ff;
            out_in.crc_ok        = (count_ff >= LW'(2)) && !ovf_ff
                                   && (crc_ff == {tail0_ff, tail1_ff});
            out_in.address_match = (count_ff != '0) && (first_ff == local_address_ff);
            out_in.overflow      = ovf_ff;
            in_frame_in          = 1'b0;
            clear                = 1'b1;
         end
      end else if (esc_ff) begin
         unique case (in_byte_ff)
            slipcrc_pkg::SymEscEnd: begin
               dec  = slipcrc_pkg::SymEnd;
               have = 1'b1;
               esc_in = 1'b0;
            end
            slipcrc_pkg::SymEscEsc: begin
               dec  = slipcrc_pkg::SymEsc;
               have = 1'b1;
               esc_in = 1'b0;
            end
            default: begin
               out_in.frame_aborted = 1'b1;
               in_frame_in          = 1'b0;
               clear                = 1'b1;
            end
         endcase
      end else if (in_byte_ff == slipcrc_pkg::SymEsc) begin
         esc_in = 1'b1;
      end else begin
         have = 1'b1;
      end

      if (have) begin
         if (count_ff < LW'(slipcrc_pkg::MaxFrame)) begin
            if (count_ff == '0) begin
               first_in = dec;
            end
            if (count_ff >= LW'(2)) begin
               crc_in = crc_fed;
            end
            tail0_in = tail1_ff;
            tail1_in = dec;
            count_in = count_ff + LW'(1);
            out_in.data_valid = 1'b1;
            out_in.data_byte  = dec;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (clear) begin
         esc_in   = 1'b0;
         count_in = '0;
         crc_in   = slipcrc_pkg::CrcInit;
         tail0_in = '0;
         tail1_in = '0;
         first_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         in_frame_ff      <= 1'b0;
         esc_ff           <= 1'b0;
         count_ff         <= '0;
         crc_ff           <= slipcrc_pkg::CrcInit;
         tail0_ff         <= '0;
         tail1_ff         <= '0;
         first_ff         <= '0;
         ovf_ff           <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            local_address_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            in_frame_ff <= in_frame_in;
            esc_ff      <= esc_in;
            count_ff    <= count_in;
            crc_ff      <= crc_in;
            tail0_ff    <= tail0_in;
            tail1_ff    <= tail1_in;
            first_ff    <= first_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_valid    = out_ff.data_valid;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_frame_done    = out_ff.frame_done;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_crc_ok        = out_ff.crc_ok;
   assign rsp_address_match = out_ff.address_match;
   assign rsp_frame_aborted = out_ff.frame_aborted;
   assign rsp_overflow      = out_ff.overflow;

endmodule

// ===== src/slipcrc_checker.sv =====
// Port-level checks for the SLIP receiver, bound to the top level.
module slipcrc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_data_valid,
   input logic [7:0]                       rsp_data_byte,
   input logic                             rsp_frame_done,
   input logic [slipcrc_pkg::LenWidth-1:0] rsp_frame_length,
   input logic                             rsp_crc_ok,
   input logic                             rsp_address_match,
   input logic                             rsp_frame_aborted,
   input logic                             rsp_overflow
);

   // a close report never carries a data byte
   a_done_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_data_valid && rsp_data_byte == 8'h00)
      else $error("close report carries data");

   // crc_ok needs a closed, clean frame of two bytes or more
   a_crc_ok_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_ok |->
         rsp_frame_done && !rsp_overflow
         && rsp_frame_length >= slipcrc_pkg::LenWidth'(2))
      else $error("crc_ok outside a valid close");

   // an abort report is alone
   a_abort_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_aborted |->
         !rsp_data_valid && !rsp_frame_done && !rsp_address_match && !rsp_overflow)
      else $error("abort mixed with other flags");

   // status flags only with a close report
   a_flags_need_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_address_match || rsp_overflow) |-> rsp_frame_done)
      else $error("frame status without close");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_frame_length) && $stable(rsp_data_valid))
      else $error("stalled result changed");

endmodule

bind slip_frame_receiver_crc_check_core slipcrc_checker u_slipcrc_checker (.*);
